// File: design/kcs_pkg.sv
// ----------------------------------------------------------------------------
// kcs_pkg
// Types, codes and framer step function for the cassette FSK decoder.
// ----------------------------------------------------------------------------
package kcs_pkg;

  localparam logic [3:0] FRAME_LEN = 4'd11;

  localparam logic [1:0] FN_EDGE    = 2'd0;
  localparam logic [1:0] FN_IDLE    = 2'd1;
  localparam logic [1:0] FN_RESTART = 2'd2;

  localparam logic [1:0] RUN_NONE  = 2'd0;
  localparam logic [1:0] RUN_SHORT = 2'd1;
  localparam logic [1:0] RUN_LONG  = 2'd2;

  localparam logic [2:0] REG_SHORT_MIN  = 3'd0;
  localparam logic [2:0] REG_LONG_MAX   = 3'd1;
  localparam logic [2:0] REG_SPLIT      = 3'd2;
  localparam logic [2:0] REG_HALVES_ONE = 3'd3;
  localparam logic [2:0] REG_HALVES_ZRO = 3'd4;
  localparam logic [2:0] REG_MIN_LEADER = 3'd5;
  localparam logic [2:0] REG_FLUSH_IDLE = 3'd6;
  localparam logic [2:0] REG_BLOCK_TOUT = 3'd7;

  localparam logic [15:0] LEAD_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    FR_HUNT,
    FR_LOCKED,
    FR_FRAME
  } fr_state_t;

  typedef enum logic [2:0] {
    K_BYTE,
    K_LOCK,
    K_ABORT,
    K_TO_LEADER,
    K_TO_BYTE
  } kind_t;

  typedef struct packed {
    fr_state_t   st;
    logic [15:0] lead;
    logic [3:0]  pos;
    logic [7:0]  shift;
  } fr_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [3:0] pos;
  } res_t;

  typedef struct packed {
    fr_t  s;
    logic emit;
    res_t r;
  } fr_out_t;

  localparam fr_t FR_RESET = '{st: FR_HUNT, lead: '0, pos: '0, shift: '0};

  function automatic logic [7:0] group_size(logic [7:0] h);
    return (h < 8'd2) ? 8'd2 : h;
  endfunction

  // rounded flush gives a bit when count + per/2 >= per
  function automatic logic flush_ok(logic [7:0] cnt, logic [7:0] per);
    return ({1'b0, cnt} + {2'b00, per[7:1]}) >= {1'b0, per};
  endfunction

  function automatic fr_out_t fr_step(fr_t s, logic b, logic [15:0] min_lead);
    fr_out_t o;
    o.s    = s;
    o.emit = 1'b0;
    o.r    = '{kind: K_BYTE, data: '0, pos: '0};
    case (s.st)
      FR_HUNT: begin
        if (b) begin
          if (s.lead != LEAD_MAX) o.s.lead = s.lead + 16'd1;
          if (o.s.lead >= min_lead) begin
            o.s.st   = FR_LOCKED;
            o.emit   = 1'b1;
            o.r.kind = K_LOCK;
          end
        end else begin
          o.s.lead = '0;
        end
      end
      FR_LOCKED: begin
        if (!b) begin
          o.s.pos   = 4'd1;
          o.s.shift = '0;
          o.s.st    = FR_FRAME;
        end
      end
      FR_FRAME: begin
        if (s.pos == 4'd0) begin
          if (!b) begin
            o.s.pos   = 4'd1;
            o.s.shift = '0;
          end
        end else if (s.pos <= 4'd8) begin
          if (b) o.s.shift[3'(s.pos - 4'd1)] = 1'b1;
          o.s.pos = s.pos + 4'd1;
        end else if (!b) begin
          o.emit   = 1'b1;
          o.r.kind = K_ABORT;
          o.r.data = s.shift;
          o.r.pos  = s.pos;
          o.s      = FR_RESET;
        end else begin
          o.s.pos = s.pos + 4'd1;
          if (o.s.pos >= FRAME_LEN) begin
            o.emit    = 1'b1;
            o.r.kind  = K_BYTE;
            o.r.data  = s.shift;
            o.s.pos   = '0;
            o.s.shift = '0;
          end
        end
      end
      default: o.s = FR_RESET;
    endcase
    return o;
  endfunction

endpackage

// File: design/kcs_cassette_fsk_decoder.sv
// ----------------------------------------------------------------------------
// kcs_cassette_fsk_decoder
// Cassette FSK decoder: half-period classing, bit grouping and UART framing.
// ----------------------------------------------------------------------------
// Input beats (in_*): tuser = func (0 edge, 1 idle check, 2 restart); tdata
// carries interval_us and idle_us. Each beat is decoded in the cycle it is
// taken; its zero, one or two results go into a four-entry result queue and
// appear on out_* once earlier results are taken, tlast marking the final
// one of a beat. Throughput is one input beat per cycle; in_tready drops
// only while the queue has fewer than two free entries, so a receiver that
// stalls on out_* holds the input back once three results are waiting.
// Registers are written through the cfg_ port (byte address 4*index); the
// user must write them only while the block is idle; the block does not
// enforce it. Reads return the stored values, pready is always high. Reset
// returns registers to their defaults, clears the run, framer and result queue.
// ----------------------------------------------------------------------------
module kcs_cassette_fsk_decoder
  import kcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [19:0] interval_us, [45:20] idle_us
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [11:8] fail_position
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef struct packed {
    res_t r;
    logic last;
  } qent_t;

  logic [15:0] short_min_r, long_max_r, split_r, min_lead_r;
  logic [7:0]  hpo_r, hpz_r;
  logic [25:0] flush_idle_r, block_tout_r;

  logic [1:0] run_kind_r, run_kind_nxt;
  logic [7:0] run_cnt_r, run_cnt_nxt;
  fr_t        fr_r, fr_nxt;

  qent_t      q_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] q_cnt_r, q_cnt_nxt;

  logic        cfg_wr;
  logic        in_acc, out_acc;
  logic [1:0]  func;
  logic [19:0] interval_us;
  logic [25:0] idle_us;

  logic       a_vld, a_bit, b_vld, b_bit;
  logic [7:0] per_run, per_cls, cnt_inc;
  logic [1:0] cls;
  logic       invalid;
  fr_out_t    st_a, st_b;
  fr_t        fr_a;
  logic       emit_a, emit_b, to_emit;
  res_t       res_a, res_b;
  qent_t      e0, e1;
  logic       push0, push1;

  assign func        = in_tuser;
  assign interval_us = in_tdata[19:0];
  assign idle_us     = in_tdata[45:20];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_paddr[4:2])
      REG_SHORT_MIN:  cfg_prdata = {16'd0, short_min_r};
      REG_LONG_MAX:   cfg_prdata = {16'd0, long_max_r};
      REG_SPLIT:      cfg_prdata = {16'd0, split_r};
      REG_HALVES_ONE: cfg_prdata = {24'd0, hpo_r};
      REG_HALVES_ZRO: cfg_prdata = {24'd0, hpz_r};
      REG_MIN_LEADER: cfg_prdata = {16'd0, min_lead_r};
      REG_FLUSH_IDLE: cfg_prdata = {6'd0, flush_idle_r};
      REG_BLOCK_TOUT: cfg_prdata = {6'd0, block_tout_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign in_tready = (q_cnt_r <= 3'd2);
  assign in_acc    = in_tvalid & in_tready;
  assign out_acc   = out_tvalid & out_tready;

  // run tracking: bit a is a rounded flush, bit b a full group
  always_comb begin
    run_kind_nxt = run_kind_r;
    run_cnt_nxt  = run_cnt_r;
    a_vld   = 1'b0;
    b_vld   = 1'b0;
    a_bit   = (run_kind_r == RUN_SHORT);
    b_bit   = 1'b0;
    per_run = group_size((run_kind_r == RUN_SHORT) ? hpo_r : hpz_r);
    invalid = (interval_us < {4'd0, short_min_r}) || (interval_us > {4'd0, long_max_r});
    cls     = (interval_us < {4'd0, split_r}) ? RUN_SHORT : RUN_LONG;
    per_cls = group_size((cls == RUN_SHORT) ? hpo_r : hpz_r);
    cnt_inc = '0;
    case (func)
      FN_EDGE: begin
        if (invalid) begin
          if (run_cnt_r != 8'd0) begin
            a_vld        = flush_ok(run_cnt_r, per_run);
            run_cnt_nxt  = '0;
            run_kind_nxt = RUN_NONE;
          end
        end else begin
          if (cls != run_kind_r) begin
            a_vld   = (run_cnt_r != 8'd0) && flush_ok(run_cnt_r, per_run);
            cnt_inc = 8'd1;
          end else begin
            cnt_inc = (run_cnt_r != 8'hFF) ? run_cnt_r + 8'd1 : run_cnt_r;
          end
          run_kind_nxt = cls;
          b_bit        = (cls == RUN_SHORT);
          if (cnt_inc >= per_cls) begin
            b_vld       = 1'b1;
            run_cnt_nxt = cnt_inc - per_cls;
          end else begin
            run_cnt_nxt = cnt_inc;
          end
        end
      end
      FN_IDLE: begin
        if (run_cnt_r != 8'd0 && idle_us > flush_idle_r) begin
          a_vld        = flush_ok(run_cnt_r, per_run);
          run_cnt_nxt  = '0;
          run_kind_nxt = RUN_NONE;
        end
      end
      default: ;
    endcase
  end

  // framer: up to two bit steps, then idle timeout or restart
  always_comb begin
    st_a    = fr_step(fr_r, a_bit, min_lead_r);
    emit_a  = a_vld & st_a.emit;
    res_a   = st_a.r;
    fr_a    = a_vld ? st_a.s : fr_r;
    st_b    = fr_step(fr_a, b_bit, min_lead_r);
    emit_b  = b_vld & st_b.emit;
    res_b   = st_b.r;
    fr_nxt  = b_vld ? st_b.s : fr_a;
    to_emit = 1'b0;
    case (func)
      FN_IDLE: begin
        if ((fr_a.st == FR_LOCKED || fr_a.st == FR_FRAME) && idle_us > block_tout_r) begin
          to_emit = 1'b1;
          res_b   = '{kind: (fr_a.st == FR_LOCKED) ? K_TO_LEADER : K_TO_BYTE,
                      data: '0, pos: '0};
          fr_nxt  = FR_RESET;
        end
      end
      FN_RESTART: fr_nxt = FR_RESET;
      default: ;
    endcase
    emit_b = emit_b | to_emit;
    push0  = emit_a | emit_b;
    push1  = emit_a & emit_b;
    e0     = '{r: emit_a ? res_a : res_b, last: ~push1};
    e1     = '{r: res_b, last: 1'b1};
  end

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (in_acc) q_cnt_nxt = q_cnt_nxt + {2'd0, push0} + {2'd0, push1};
    if (out_acc) q_cnt_nxt = q_cnt_nxt - 3'd1;
  end

  assign out_tvalid = (q_cnt_r != 3'd0);
  assign out_tuser  = q_r[rd_ptr_r].r.kind;
  assign out_tdata  = {4'd0, q_r[rd_ptr_r].r.pos, q_r[rd_ptr_r].r.data};
  assign out_tlast  = q_r[rd_ptr_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_min_r  <= 16'd100;
      long_max_r   <= 16'd600;
      split_r      <= 16'd312;
      hpo_r        <= 8'd16;
      hpz_r        <= 8'd8;
      min_lead_r   <= 16'd100;
      flush_idle_r <= 26'd2000;
      block_tout_r <= 26'd2000000;
      run_kind_r   <= RUN_NONE;
      run_cnt_r    <= '0;
      fr_r         <= FR_RESET;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      q_cnt_r      <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          REG_SHORT_MIN:  short_min_r  <= cfg_pwdata[15:0];
          REG_LONG_MAX:   long_max_r   <= cfg_pwdata[15:0];
          REG_SPLIT:      split_r      <= cfg_pwdata[15:0];
          REG_HALVES_ONE: hpo_r        <= cfg_pwdata[7:0];
          REG_HALVES_ZRO: hpz_r        <= cfg_pwdata[7:0];
          REG_MIN_LEADER: min_lead_r   <= cfg_pwdata[15:0];
          REG_FLUSH_IDLE: flush_idle_r <= cfg_pwdata[25:0];
          REG_BLOCK_TOUT: block_tout_r <= cfg_pwdata[25:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        run_kind_r <= run_kind_nxt;
        run_cnt_r  <= run_cnt_nxt;
        fr_r       <= fr_nxt;
        wr_ptr_r   <= wr_ptr_r + {1'b0, push0} + {1'b0, push1};
      end
      if (out_acc) rd_ptr_r <= rd_ptr_r + 2'd1;
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && push0) q_r[wr_ptr_r] <= e0;
    if (in_acc && push1) q_r[wr_ptr_r + 2'd1] <= e1;
  end

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 3'd4)
    else $error("result queue overfilled");

  a_run_kind: assert property (@(posedge clk) disable iff (!rst_n)
    run_cnt_r != 8'd0 |-> run_kind_r != RUN_NONE)
    else $error("pending run without a class");

  a_frame_pos: assert property (@(posedge clk) disable iff (!rst_n)
    fr_r.pos == 4'd0 |-> fr_r.shift == 8'd0)
    else $error("partial byte outside a frame");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    fr_r.pos < FRAME_LEN)
    else $error("frame position past frame end");

endmodule
